### rtl/core/three_photon_dalitz_event_builder_core_assert.svh
// assertion macros shared by the core rtl
`ifndef THREE_PHOTON_DALITZ_EVENT_BUILDER_CORE_ASSERT_SVH
`define THREE_PHOTON_DALITZ_EVENT_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TPDEB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TPDEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tpdeb_pkg.sv
`default_nettype none

package tpdeb_pkg;

  localparam int EventW        = 31;
  localparam int SlotW         = 8;
  localparam int EnergyBits    = 20;
  localparam int CoordFracBits = 15;
  localparam int CoordW        = 16;
  localparam int TotW          = EnergyBits + 2;
  localparam int NumW          = EnergyBits + 3;
  localparam int QuotFracBits  = 30;
  localparam int QuotW         = QuotFracBits + 2;
  localparam int DivSteps      = QuotFracBits / 2;
  localparam int CntW          = $clog2(DivSteps);
  localparam int KW            = 32;
  localparam int ProdW         = QuotW + KW;
  localparam int RoundShift    = 62 - CoordFracBits;

  localparam logic [KW-1:0]    InvSqrt2    = 32'd3037000500;
  localparam logic [KW-1:0]    InvSqrt6    = 32'd1753413056;
  localparam logic [ProdW-1:0] RoundBias   = ProdW'(1) << (61 - CoordFracBits);
  localparam logic [ProdW-1:0] CoordPosMax = ProdW'(32767);
  localparam logic [ProdW-1:0] CoordNegMax = ProdW'(32768);
  localparam logic [2:0]       AllSeen     = 3'b111;

  typedef enum logic [2:0] {
    SeqIdle,
    SeqPrep,
    SeqXGo,
    SeqXWait,
    SeqYGo,
    SeqYWait,
    SeqEmit
  } seq_state_e;

  typedef enum logic [1:0] {
    CuIdle,
    CuDiv,
    CuMul,
    CuRnd
  } cu_state_e;

  typedef struct packed {
    logic                   start;
    logic                   use_sqrt6;
    logic signed [NumW-1:0] num;
    logic [TotW-1:0]        tot;
  } cu_req_t;

  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] coord;
  } cu_rsp_t;

endpackage

`default_nettype wire

### rtl/core/three_photon_dalitz_event_builder_core.sv
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+------------------------------------------
// in      | input     | in_valid_i / in_ready_o | event_number, photon_slot, hit_energy,
//         |           |                         | stream_end
// out     | output    | out_valid_o/out_ready_i | coord_x, coord_y, run_last
// cfg     | input     | cfg_we_i (no wait)      | cfg_wdata_i = sort_energies
//
// a word that closes no event leaves the core idle, ready again the next cycle
// each finished event takes two passes of the shared divider
//   (radix-4, 15 steps) with one 32x32 multiply and a rounding step each
// a word that closes two events runs both events through the divider in turn
// a held result word blocks input only while the sequencer waits in SeqEmit to load the next one
// reset clears the open event, the mode bit and the output valid bit
`default_nettype none

`include "three_photon_dalitz_event_builder_core_assert.svh"

module three_photon_dalitz_event_builder_core
  import tpdeb_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [EventW-1:0]        event_number_i,
  input  wire logic signed [SlotW-1:0]  photon_slot_i,
  input  wire logic [EnergyBits-1:0]    hit_energy_i,
  input  wire logic                     stream_end_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [CoordW-1:0]      coord_x_o,
  output logic signed [CoordW-1:0]      coord_y_o,
  output logic                          run_last_o
);

  seq_state_e             state_q, state_d;
  logic                   sort_q;
  logic [EventW-1:0]      open_ev_q;
  logic                   event_open_q;
  logic [EnergyBits-1:0]  energy_q [3];
  logic [2:0]             seen_q;
  logic [EnergyBits-1:0]  cur_e_q [3];
  logic [EnergyBits-1:0]  next_e_q [3];
  logic                   has_next_q;
  logic signed [NumW-1:0] num_x_q, num_y_q;
  logic [TotW-1:0]        tot_q;
  logic [CoordW-1:0]      x_res_q;
  logic                   out_valid_q;
  logic [CoordW-1:0]      out_x_q, out_y_q;
  logic                   out_last_q;

  logic                   in_acc;
  logic                   change;
  logic                   old_emit, new_emit;
  logic [EnergyBits-1:0]  base_e [3];
  logic [2:0]             base_seen;
  logic [EnergyBits-1:0]  new_e [3];
  logic [2:0]             new_seen;
  logic                   slot_ok;
  logic [1:0]             slot_idx;
  logic [TotW-1:0]        old_tot, new_tot;
  logic [EnergyBits-1:0]  s0, s1, s2, t0, t1, u0, u1;
  logic                   out_free;
  logic                   load_out;
  cu_req_t                cu_req;
  cu_rsp_t                cu_rsp;

  assign in_ready_o = (state_q == SeqIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == SeqEmit) && out_free;

  // event bookkeeping for the word at the input
  always_comb begin
    change    = event_open_q && (event_number_i != open_ev_q);
    old_tot   = TotW'(energy_q[0]) + TotW'(energy_q[1]) + TotW'(energy_q[2]);
    old_emit  = change && (seen_q == AllSeen) && (old_tot != '0);
    slot_ok   = (photon_slot_i[SlotW-1:2] == '0) && (photon_slot_i[1:0] != 2'd3);
    slot_idx  = photon_slot_i[1:0];
    base_seen = change ? 3'b000 : seen_q;
    for (int i = 0; i < 3; i++) begin
      base_e[i] = change ? '0 : energy_q[i];
      new_e[i]  = base_e[i];
    end
    new_seen = base_seen;
    if (slot_ok && !base_seen[slot_idx]) begin
      new_e[slot_idx]    = hit_energy_i;
      new_seen[slot_idx] = 1'b1;
    end
    new_tot  = TotW'(new_e[0]) + TotW'(new_e[1]) + TotW'(new_e[2]);
    new_emit = stream_end_i && (new_seen == AllSeen) && (new_tot != '0);
  end

  // optional ascending sort of the current triple
  always_comb begin
    s0 = cur_e_q[0];
    s1 = cur_e_q[1];
    s2 = cur_e_q[2];
    if (sort_q) begin
      t0 = (s0 > s1) ? s1 : s0;
      t1 = (s0 > s1) ? s0 : s1;
      u1 = (t1 > s2) ? s2 : t1;
      s2 = (t1 > s2) ? t1 : s2;
      u0 = (t0 > u1) ? u1 : t0;
      s1 = (t0 > u1) ? t0 : u1;
      s0 = u0;
    end else begin
      t0 = '0;
      t1 = '0;
      u0 = '0;
      u1 = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SeqIdle: begin
        if (in_acc && (old_emit || new_emit)) begin
          state_d = SeqPrep;
        end
      end
      SeqPrep:  state_d = SeqXGo;
      SeqXGo:   state_d = SeqXWait;
      SeqXWait: if (cu_rsp.done) state_d = SeqYGo;
      SeqYGo:   state_d = SeqYWait;
      SeqYWait: if (cu_rsp.done) state_d = SeqEmit;
      SeqEmit: begin
        if (out_free) begin
          state_d = has_next_q ? SeqPrep : SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  always_comb begin
    cu_req.start     = (state_q == SeqXGo) || (state_q == SeqYGo);
    cu_req.use_sqrt6 = (state_q == SeqYGo);
    cu_req.num       = (state_q == SeqYGo) ? num_y_q : num_x_q;
    cu_req.tot       = tot_q;
  end

  tpdeb_coord_unit u_coord (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cu_req),
    .rsp_o  (cu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SeqIdle;
      sort_q       <= 1'b0;
      open_ev_q    <= '0;
      event_open_q <= 1'b0;
      seen_q       <= '0;
      energy_q     <= '{default: '0};
      has_next_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        sort_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        open_ev_q    <= event_number_i;
        event_open_q <= !stream_end_i;
        seen_q       <= stream_end_i ? 3'b000 : new_seen;
        for (int i = 0; i < 3; i++) begin
          energy_q[i] <= stream_end_i ? '0 : new_e[i];
        end
        has_next_q <= old_emit && new_emit;
      end else if (load_out && has_next_q) begin
        has_next_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        cur_e_q[i]  <= old_emit ? energy_q[i] : new_e[i];
        next_e_q[i] <= new_e[i];
      end
    end else if (load_out && has_next_q) begin
      cur_e_q <= next_e_q;
    end
    if (state_q == SeqPrep) begin
      tot_q   <= TotW'(s0) + TotW'(s1) + TotW'(s2);
      num_x_q <= NumW'(s1) - NumW'(s0);
      num_y_q <= (NumW'(s2) <<< 1) - NumW'(s0) - NumW'(s1);
    end
    if ((state_q == SeqXWait) && cu_rsp.done) begin
      x_res_q <= cu_rsp.coord;
    end
    if (load_out) begin
      out_x_q    <= x_res_q;
      out_y_q    <= cu_rsp.coord;
      out_last_q <= !has_next_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign coord_x_o   = out_x_q;
  assign coord_y_o   = out_y_q;
  assign run_last_o  = out_last_q;

  `TPDEB_ASSERT_NOW(a_done_when_waiting, cu_rsp.done,
                    (state_q == SeqXWait) || (state_q == SeqYWait),
                    "divider result with no pass waiting")
  `TPDEB_ASSERT_NEXT(a_emit_loads_out, load_out, out_valid_q,
                     "result word not loaded")
  `TPDEB_ASSERT_NEXT(a_end_closes_event, in_acc && stream_end_i, !event_open_q,
                     "event left open after stream end")
  `TPDEB_ASSERT_NOW(a_next_only_busy, has_next_q, state_q != SeqIdle,
                    "second event pending while idle")

endmodule

`default_nettype wire

### rtl/core/tpdeb_coord_unit.sv
`default_nettype none

module tpdeb_coord_unit
  import tpdeb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cu_req_t req_i,
  output cu_rsp_t      rsp_o
);

  cu_state_e             state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [TotW-1:0]       d_q, d_d;
  logic [TotW-1:0]       r_q, r_d;
  logic [QuotW-1:0]      q_q, q_d;
  logic                  neg_q, neg_d;
  logic                  k6_q, k6_d;
  logic [ProdW-1:0]      p_q, p_d;
  logic [CoordW-1:0]     coord_q, coord_d;
  logic                  done_q, done_d;

  logic [NumW-1:0]       mag;
  logic [NumW-1:0]       two_tot;
  logic [NumW-1:0]       one_tot;
  logic [1:0]            q0;
  logic [TotW-1:0]       r0;
  logic [TotW:0]         r1s, r2s;
  logic [TotW-1:0]       r1, r2;
  logic                  b1, b0;
  logic [ProdW-1:0]      v;
  logic [ProdW-1:0]      vs;

  always_comb begin
    mag     = req_i.num[NumW-1] ? NumW'(-req_i.num) : NumW'(req_i.num);
    two_tot = {req_i.tot, 1'b0};
    one_tot = {1'b0, req_i.tot};
    if (mag >= two_tot) begin
      q0 = 2'd2;
      r0 = TotW'(mag - two_tot);
    end else if (mag >= one_tot) begin
      q0 = 2'd1;
      r0 = TotW'(mag - one_tot);
    end else begin
      q0 = 2'd0;
      r0 = TotW'(mag);
    end

    // two restoring steps per cycle
    r1s = {r_q, 1'b0};
    b1  = r1s >= {1'b0, d_q};
    r1  = b1 ? TotW'(r1s - {1'b0, d_q}) : TotW'(r1s);
    r2s = {r1, 1'b0};
    b0  = r2s >= {1'b0, d_q};
    r2  = b0 ? TotW'(r2s - {1'b0, d_q}) : TotW'(r2s);

    v = (p_q + RoundBias) >> RoundShift;
    if (neg_q) begin
      vs = (v > CoordNegMax) ? CoordNegMax : v;
    end else begin
      vs = (v > CoordPosMax) ? CoordPosMax : v;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    d_d     = d_q;
    r_d     = r_q;
    q_d     = q_q;
    neg_d   = neg_q;
    k6_d    = k6_q;
    p_d     = p_q;
    coord_d = coord_q;
    done_d  = 1'b0;
    unique case (state_q)
      CuIdle: begin
        if (req_i.start) begin
          d_d     = req_i.tot;
          r_d     = r0;
          q_d     = QuotW'(q0);
          neg_d   = req_i.num[NumW-1];
          k6_d    = req_i.use_sqrt6;
          cnt_d   = CntW'(DivSteps - 1);
          state_d = CuDiv;
        end
      end
      CuDiv: begin
        r_d = r2;
        q_d = {q_q[QuotW-3:0], b1, b0};
        if (cnt_q == '0) begin
          state_d = CuMul;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      CuMul: begin
        p_d     = ProdW'(q_q) * ProdW'(k6_q ? InvSqrt6 : InvSqrt2);
        state_d = CuRnd;
      end
      CuRnd: begin
        coord_d = neg_q ? CoordW'(ProdW'(0) - vs) : CoordW'(vs);
        done_d  = 1'b1;
        state_d = CuIdle;
      end
      default: state_d = CuIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CuIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    d_q     <= d_d;
    r_q     <= r_d;
    q_q     <= q_d;
    neg_q   <= neg_d;
    k6_q    <= k6_d;
    p_q     <= p_d;
    coord_q <= coord_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.coord = coord_q;

endmodule

`default_nettype wire
